// ===== hw/rtl/lkv_pkg.sv =====
// Shared types, codes and microcode word layout for the linked key/value table.
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 64;
   localparam int SLOT_W   = 10;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int STEP_W   = 4;

   localparam logic [OP_W-1:0] OP_SET    = 2'd0;
   localparam logic [OP_W-1:0] OP_GET    = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE     = 4'd0;
   localparam step_type STEP_LOOK     = 4'd1;
   localparam step_type STEP_WALK     = 4'd2;
   localparam step_type STEP_DISPATCH = 4'd3;
   localparam step_type STEP_SET_UPD  = 4'd4;
   localparam step_type STEP_SET_READ = 4'd5;
   localparam step_type STEP_SET_ADD  = 4'd6;
   localparam step_type STEP_GET_READ = 4'd7;
   localparam step_type STEP_GET_OUT  = 4'd8;
   localparam step_type STEP_DEL_LINK = 4'd9;
   localparam step_type STEP_DEL_FREE = 4'd10;
   localparam step_type STEP_MISS     = 4'd11;
   localparam step_type STEP_FULL     = 4'd12;

   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_LATCH,
      UOP_WALK_INIT,
      UOP_WALK,
      UOP_WRITE_VALUE,
      UOP_READ_FREE,
      UOP_ALLOC,
      UOP_READ_VALUE,
      UOP_FOUND,
      UOP_UNLINK,
      UOP_PUSH_FREE,
      UOP_RESPOND
   } uop_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_IF_IDLE,
      JMP_IF_MORE,
      JMP_IF_BAD_OP,
      JMP_DISPATCH
   } jump_type;

   typedef struct packed {
      uop_type               uop;
      jump_type              jump;
      step_type              target;
      logic                  rsp_en;
      logic [STATUS_W-1:0]   status;
   } lkv_ctrl_type;

   typedef struct packed {
      logic                start;
      logic                walk_more;
      logic                bad_op;
      logic                hit;
      logic                full;
      logic [OP_W-1:0]     op;
   } lkv_flags_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [KEY_W-1:0]  key_hash;
      logic [VALUE_W-1:0]       value_word;
   } lkv_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic [SLOT_W-1:0]   slot;
   } lkv_rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lkv_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lkv_sequencer.sv =====
// Microcode store and step counter that drive the key/value table datapath.
`timescale 1ns / 1ps
`default_nettype none

module lkv_sequencer import lkv_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lkv_flags_type flags,
   output lkv_ctrl_type       ctrl,
   output logic               busy
);

   step_type upc_ff;
   step_type upc_in;
   step_type dispatch_step;

   function automatic lkv_ctrl_type ucode(input step_type step);
      lkv_ctrl_type w;
      w.uop    = UOP_NONE;
      w.jump   = JMP_ALWAYS;
      w.target = STEP_IDLE;
      w.rsp_en = 1'b0;
      w.status = ST_NOT_FOUND;
      unique case (step)
         STEP_IDLE: begin
            w.uop    = UOP_LATCH;
            w.jump   = JMP_IF_IDLE;
            w.target = STEP_IDLE;
         end
         STEP_LOOK: begin
            w.uop    = UOP_WALK_INIT;
            w.jump   = JMP_IF_BAD_OP;
            w.target = STEP_MISS;
         end
         STEP_WALK: begin
            w.uop    = UOP_WALK;
            w.jump   = JMP_IF_MORE;
            w.target = STEP_WALK;
         end
         STEP_DISPATCH: begin
            w.jump = JMP_DISPATCH;
         end
         STEP_SET_UPD: begin
            w.uop    = UOP_WRITE_VALUE;
            w.rsp_en = 1'b1;
            w.status = ST_UPDATED;
         end
         STEP_SET_READ: begin
            w.uop  = UOP_READ_FREE;
            w.jump = JMP_NEXT;
         end
         STEP_SET_ADD: begin
            w.uop    = UOP_ALLOC;
            w.rsp_en = 1'b1;
            w.status = ST_ADDED;
         end
         STEP_GET_READ: begin
            w.uop  = UOP_READ_VALUE;
            w.jump = JMP_NEXT;
         end
         STEP_GET_OUT: begin
            w.uop    = UOP_FOUND;
            w.rsp_en = 1'b1;
            w.status = ST_FOUND;
         end
         STEP_DEL_LINK: begin
            w.uop  = UOP_UNLINK;
            w.jump = JMP_NEXT;
         end
         STEP_DEL_FREE: begin
            w.uop    = UOP_PUSH_FREE;
            w.rsp_en = 1'b1;
            w.status = ST_REMOVED;
         end
         STEP_MISS: begin
            w.uop    = UOP_RESPOND;
            w.rsp_en = 1'b1;
            w.status = ST_NOT_FOUND;
         end
         STEP_FULL: begin
            w.uop    = UOP_RESPOND;
            w.rsp_en = 1'b1;
            w.status = ST_FULL;
         end
         default: begin
            w.jump = JMP_ALWAYS;
         end
      endcase
      return w;
   endfunction

   assign ctrl = ucode(upc_ff);
   assign busy = (upc_ff != STEP_IDLE);

   // Multi-way branch once the walk has settled whether the key is present.
   always_comb begin
      unique case (flags.op)
         OP_SET: begin
            if (flags.hit) begin
               dispatch_step = STEP_SET_UPD;
            end else if (flags.full) begin
               dispatch_step = STEP_FULL;
            end else begin
               dispatch_step = STEP_SET_READ;
            end
         end
         OP_GET:    dispatch_step = flags.hit ? STEP_GET_READ : STEP_MISS;
         OP_DELETE: dispatch_step = flags.hit ? STEP_DEL_LINK : STEP_MISS;
         default:   dispatch_step = STEP_MISS;
      endcase
   end

   always_comb begin
      unique case (ctrl.jump)
         JMP_NEXT:      upc_in = upc_ff + 1'b1;
         JMP_ALWAYS:    upc_in = ctrl.target;
         JMP_IF_IDLE:   upc_in = flags.start ? upc_ff + 1'b1 : ctrl.target;
         JMP_IF_MORE:   upc_in = flags.walk_more ? ctrl.target : upc_ff + 1'b1;
         JMP_IF_BAD_OP: upc_in = flags.bad_op ? ctrl.target : upc_ff + 1'b1;
         JMP_DISPATCH:  upc_in = dispatch_step;
         default:       upc_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/linked_key_value_table.sv =====
// Top level of the linked key/value table: datapath, pool memories and sequencer.
`timescale 1ns / 1ps
`default_nettype none

// A request (set, get or delete with a 32-bit key hash) is taken when start is high and
// busy is low. The block walks its list of used slots one node per clock cycle, reading
// the key and link memories at the same address, then acts on the outcome. One result
// beat follows every request: rsp_valid is high for exactly one cycle and the receiver
// must take it then. An unknown op skips the list walk and goes straight to its
// not-found result; for the other ops the list walk through the link memory sets how
// long a request takes, which grows with the number of used slots. Busy drops as the
// result beat starts, so the next request can be taken at the edge that ends the beat.
// No clearing pass is needed after reset: slots never yet handed out are tracked by a
// fill mark, so the block accepts a request in the first cycle after reset.
module linked_key_value_table import lkv_pkg::*; #(
   parameter int ENTRIES    = 1024,
   parameter int VALUE_BITS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire lkv_req_type req,
   output logic             busy,
   output logic             rsp_valid,
   output lkv_rsp_type      rsp
);

   localparam int AW = $clog2(ENTRIES);
   localparam int PW = $clog2(ENTRIES + 1);
   localparam logic [PW-1:0] ENTRIES_P = PW'(ENTRIES);

   lkv_ctrl_type  ctrl;
   lkv_flags_type flags;

   logic [OP_W-1:0]        op_ff, op_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [VALUE_BITS-1:0]  val_ff, val_in;
   logic [PW-1:0]          cur_ff, cur_in;
   logic [PW-1:0]          prev_ff, prev_in;
   logic                   have_prev_ff, have_prev_in;
   logic [PW-1:0]          n_ff, n_in;
   logic [PW-1:0]          at_ff, at_in;
   logic [PW-1:0]          before_ff, before_in;
   logic                   has_before_ff, has_before_in;
   logic                   hit_ff, hit_in;
   logic [PW-1:0]          nxt_ff, nxt_in;
   logic [PW-1:0]          used_head_ff, used_head_in;
   logic [PW-1:0]          used_tail_ff, used_tail_in;
   logic [PW-1:0]          free_head_ff, free_head_in;
   logic [PW-1:0]          count_ff, count_in;
   logic [PW-1:0]          fresh_ff, fresh_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lkv_rsp_type            rsp_ff, rsp_in;

   logic [PW-1:0]          rd_addr;
   logic [KEY_W-1:0]       key_q;
   logic [VALUE_BITS-1:0]  val_q;
   logic [PW-1:0]          link_q;
   logic                   key_we;
   logic                   val_we;
   logic [PW-1:0]          val_waddr;
   logic                   link_we;
   logic [PW-1:0]          link_waddr;
   logic [PW-1:0]          link_wdata;

   logic [PW-1:0]          link_eff;
   logic                   walk_stop;
   logic                   walk_match;
   logic                   walk_more;

   lkv_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   lkv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (free_head_ff[AW-1:0]),
      .wr_data (key_ff),
      .rd_addr (rd_addr[AW-1:0]),
      .rd_data (key_q)
   );

   lkv_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr[AW-1:0]),
      .wr_data (val_ff),
      .rd_addr (rd_addr[AW-1:0]),
      .rd_data (val_q)
   );

   lkv_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr[AW-1:0]),
      .wr_data (link_wdata),
      .rd_addr (rd_addr[AW-1:0]),
      .rd_data (link_q)
   );

   // Slots at or above the fill mark were never linked by hand and still point to
   // the next slot up, as after reset.
   assign link_eff = (cur_ff >= fresh_ff) ? cur_ff + 1'b1 : link_q;

   assign walk_stop  = (n_ff == count_ff) || (cur_ff >= ENTRIES_P);
   assign walk_match = !walk_stop && (key_q == key_ff);
   assign walk_more  = !walk_stop && !walk_match;

   always_comb begin
      flags.start     = start;
      flags.walk_more = walk_more;
      flags.bad_op    = !((op_ff == OP_SET) || (op_ff == OP_GET) || (op_ff == OP_DELETE));
      flags.hit       = hit_ff;
      flags.full      = (count_ff >= ENTRIES_P) || (free_head_ff >= ENTRIES_P);
      flags.op        = op_ff;
   end

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      n_in          = n_ff;
      at_in         = at_ff;
      before_in     = before_ff;
      has_before_in = has_before_ff;
      hit_in        = hit_ff;
      nxt_in        = nxt_ff;
      used_head_in  = used_head_ff;
      used_tail_in  = used_tail_ff;
      free_head_in  = free_head_ff;
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      rd_addr       = cur_ff;
      key_we        = 1'b0;
      val_we        = 1'b0;
      val_waddr     = at_ff;
      link_we       = 1'b0;
      link_waddr    = at_ff;
      link_wdata    = free_head_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;

      unique case (ctrl.uop)
         UOP_LATCH: begin
            if (start) begin
               op_in  = req.op;
               key_in = req.key_hash;
               val_in = req.value_word[VALUE_BITS-1:0];
               hit_in = 1'b0;
            end
         end
         UOP_WALK_INIT: begin
            cur_in       = used_head_ff;
            n_in         = '0;
            have_prev_in = 1'b0;
            rd_addr      = used_head_ff;
         end
         UOP_WALK: begin
            if (walk_match) begin
               hit_in        = 1'b1;
               at_in         = cur_ff;
               before_in     = prev_ff;
               has_before_in = have_prev_ff;
               nxt_in        = link_eff;
            end else if (walk_more) begin
               // Feed the link straight back as the next read address.
               prev_in      = cur_ff;
               have_prev_in = 1'b1;
               cur_in       = link_eff;
               n_in         = n_ff + 1'b1;
               rd_addr      = link_eff;
            end
         end
         UOP_WRITE_VALUE: begin
            val_we = 1'b1;
         end
         UOP_READ_FREE: begin
            cur_in  = free_head_ff;
            rd_addr = free_head_ff;
         end
         UOP_ALLOC: begin
            key_we       = 1'b1;
            val_we       = 1'b1;
            val_waddr    = free_head_ff;
            free_head_in = link_eff;
            if (count_ff == '0) begin
               used_head_in = free_head_ff;
            end else begin
               link_we    = 1'b1;
               link_waddr = used_tail_ff;
               link_wdata = free_head_ff;
            end
            used_tail_in = free_head_ff;
            count_in     = count_ff + 1'b1;
            if (free_head_ff >= fresh_ff) begin
               fresh_in = free_head_ff + 1'b1;
            end
         end
         UOP_READ_VALUE: begin
            rd_addr = at_ff;
         end
         UOP_UNLINK: begin
            if (has_before_ff) begin
               link_we    = 1'b1;
               link_waddr = before_ff;
               link_wdata = nxt_ff;
            end else begin
               used_head_in = nxt_ff;
            end
            if (at_ff == used_tail_ff) begin
               used_tail_in = has_before_ff ? before_ff : '0;
            end
            count_in = count_ff - 1'b1;
            if (count_ff == PW'(1)) begin
               used_head_in = '0;
               used_tail_in = '0;
            end
         end
         UOP_PUSH_FREE: begin
            link_we      = 1'b1;
            free_head_in = at_ff;
         end
         default: begin
         end
      endcase

      if (ctrl.rsp_en) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = ctrl.status;
         rsp_in.read_value = '0;
         rsp_in.slot       = '0;
         unique case (ctrl.uop)
            UOP_FOUND: begin
               rsp_in.read_value = VALUE_W'(val_q);
               rsp_in.slot       = SLOT_W'(at_ff);
            end
            UOP_ALLOC: begin
               rsp_in.slot = SLOT_W'(free_head_ff);
            end
            UOP_WRITE_VALUE, UOP_PUSH_FREE: begin
               rsp_in.slot = SLOT_W'(at_ff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_head_ff <= '0;
         used_tail_ff <= '0;
         free_head_ff <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_head_ff <= used_head_in;
         used_tail_ff <= used_tail_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      have_prev_ff  <= have_prev_in;
      n_ff          <= n_in;
      at_ff         <= at_in;
      before_ff     <= before_in;
      has_before_ff <= has_before_in;
      hit_ff        <= hit_in;
      nxt_ff        <= nxt_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ENTRIES_P)
      else $error("used count exceeds the pool size");

   a_fresh_grows: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> fresh_ff >= $past(fresh_ff))
      else $error("fill mark moved backward");

   a_free_below_fresh: assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= fresh_ff)
      else $error("free list head lies beyond the fill mark");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_done_with_beat: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid_ff)
      else $error("request finished without a result beat");

endmodule

`default_nettype wire
